### design/assert_macros.svh
// Assertion macros shared by the hoist interlock RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/hmi_pkg.sv
// Package for the hoist motion interlock: codes, widths and shared structs.
// Used by the step logic and the top level; depends on nothing.
`default_nettype none

package hmi_pkg;

    localparam int POS_WIDTH = 32;
    localparam int DATA_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_MOTION = 2'd1,
        CMD_TARGET = 2'd2,
        CMD_TEST   = 2'd3
    } cmd_t;

    localparam logic [1:0] MOT_STOP = 2'd0;
    localparam logic [1:0] MOT_FWD  = 2'd1;
    localparam logic [1:0] MOT_REV  = 2'd2;

    localparam logic [1:0] TM_NONE = 2'd0;
    localparam logic [1:0] TM_BR1  = 2'd1;
    localparam logic [1:0] TM_BR2  = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECT_MODE = 2'd2;

    localparam logic [3:0] EV_NONE          = 4'd0;
    localparam logic [3:0] EV_NO_SUPPLY     = 4'd1;
    localparam logic [3:0] EV_UPPER_BLOCK   = 4'd2;
    localparam logic [3:0] EV_LOWER_BLOCK   = 4'd3;
    localparam logic [3:0] EV_UPPER_STOP    = 4'd4;
    localparam logic [3:0] EV_LOWER_STOP    = 4'd5;
    localparam logic [3:0] EV_TARGET_REACHED = 4'd6;
    localparam logic [3:0] EV_RUN_FWD       = 4'd7;
    localparam logic [3:0] EV_RUN_REV       = 4'd8;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] upper_limit;
        logic signed [POS_WIDTH-1:0] lower_limit;
        logic                        direct_mode;
    } cfg_t;

    typedef struct packed {
        cmd_t                        cmd;
        logic [1:0]                  direction;
        logic signed [POS_WIDTH-1:0] target_position;
        logic [1:0]                  test_mode_request;
        logic signed [POS_WIDTH-1:0] position;
        logic                        supply_ok;
    } item_t;

    typedef struct packed {
        logic [1:0]                  motion;
        logic [1:0]                  test_mode;
        logic signed [POS_WIDTH-1:0] target;
        logic                        target_active;
        logic                        last_br1;
        logic                        last_br2;
    } state_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] motion_state;
        logic       target_tracking;
        logic [1:0] test_mode_now;
        logic       forward_contactor;
        logic       reverse_contactor;
        logic       brake_one_open;
        logic       brake_two_open;
        logic       brake_one_opened;
        logic       brake_two_opened;
        logic [3:0] event_code;
    } result_t;

endpackage

`default_nettype wire

### design/hmi_if.sv
// Handshake channels of the hoist motion interlock: command words in, status words out.
// Standalone; no package needed.
`default_nettype none

interface hmi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [1:0]         direction;
    logic signed [31:0] target_position;
    logic [1:0]         test_mode_request;
    logic signed [31:0] position;
    logic               supply_ok;

    modport source (output valid, output cmd, output direction, output target_position,
                    output test_mode_request, output position, output supply_ok,
                    input ready);
    modport sink (input valid, input cmd, input direction, input target_position,
                  input test_mode_request, input position, input supply_ok,
                  output ready);
endinterface

interface hmi_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] motion_state;
    logic       target_tracking;
    logic [1:0] test_mode_now;
    logic       forward_contactor;
    logic       reverse_contactor;
    logic       brake_one_open;
    logic       brake_two_open;
    logic       brake_one_opened;
    logic       brake_two_opened;
    logic [3:0] event_code;

    modport source (output valid, output accepted, output motion_state,
                    output target_tracking, output test_mode_now, output forward_contactor,
                    output reverse_contactor, output brake_one_open, output brake_two_open,
                    output brake_one_opened, output brake_two_opened, output event_code,
                    input ready);
    modport sink (input valid, input accepted, input motion_state,
                  input target_tracking, input test_mode_now, input forward_contactor,
                  input reverse_contactor, input brake_one_open, input brake_two_open,
                  input brake_one_opened, input brake_two_opened, input event_code,
                  output ready);
endinterface

`default_nettype wire

### design/hmi_step.sv
// Combinational step of the hoist interlock: next state and status word for one command.
// Depends on hmi_pkg.
`default_nettype none

module hmi_step
    import hmi_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  st,
    input  item_t   inp,
    output state_t  st_next,
    output result_t res
);

    logic [1:0] dir;
    logic [1:0] tm;
    logic [1:0] req_dir;
    logic       pos_eq;
    logic       tgt_above;
    logic       at_upper;
    logic       at_lower;
    logic       blk_supply;
    logic       blk_upper;
    logic       blk_lower;
    logic       new_target;
    logic       acc;
    logic [3:0] ev;
    logic       fw;
    logic       rv;
    logic       br1;
    logic       br2;

    always_comb
    begin
        dir = (inp.direction == MOT_FWD || inp.direction == MOT_REV) ? inp.direction : MOT_STOP;
        tm  = (inp.test_mode_request == TM_BR1 || inp.test_mode_request == TM_BR2)
            ? inp.test_mode_request : TM_NONE;

        pos_eq    = (inp.target_position == inp.position);
        tgt_above = (inp.target_position > inp.position);
        at_upper  = (inp.position >= cfg.upper_limit);
        at_lower  = (inp.position <= cfg.lower_limit);

        case (inp.cmd)
            CMD_TARGET: req_dir = pos_eq ? MOT_STOP : (tgt_above ? MOT_FWD : MOT_REV);
            default:    req_dir = dir;
        endcase

        new_target = (inp.cmd == CMD_TARGET) && !pos_eq;
        blk_supply = cfg.direct_mode && (req_dir == MOT_FWD) && !inp.supply_ok;
        blk_upper  = (req_dir == MOT_FWD) && at_upper;
        blk_lower  = (req_dir == MOT_REV) && at_lower;

        st_next = st;
        acc     = 1'b1;
        ev      = EV_NONE;

        case (inp.cmd)
            CMD_TICK:
            begin
                if (st.motion == MOT_FWD && at_upper)
                begin
                    st_next.motion        = MOT_STOP;
                    st_next.target_active = 1'b0;
                    ev                    = EV_UPPER_STOP;
                end
                else if (st.motion == MOT_REV && at_lower)
                begin
                    st_next.motion        = MOT_STOP;
                    st_next.target_active = 1'b0;
                    ev                    = EV_LOWER_STOP;
                end
                else if (st.target_active &&
                         ((st.motion == MOT_FWD && inp.position >= st.target) ||
                          (st.motion == MOT_REV && inp.position <= st.target)))
                begin
                    st_next.motion        = MOT_STOP;
                    st_next.target_active = 1'b0;
                    ev                    = EV_TARGET_REACHED;
                end
            end
            CMD_MOTION, CMD_TARGET:
            begin
                if (new_target)
                begin
                    st_next.target        = inp.target_position;
                    st_next.target_active = 1'b1;
                end
                if (blk_supply)
                begin
                    acc = 1'b0;
                    ev  = EV_NO_SUPPLY;
                end
                else if (blk_upper)
                begin
                    acc = 1'b0;
                    ev  = EV_UPPER_BLOCK;
                end
                else if (blk_lower)
                begin
                    acc = 1'b0;
                    ev  = EV_LOWER_BLOCK;
                end
                else
                begin
                    st_next.motion = req_dir;
                    if (req_dir == MOT_STOP)
                    begin
                        st_next.target_active = 1'b0;
                    end
                    if (new_target)
                    begin
                        ev = (req_dir == MOT_FWD) ? EV_RUN_FWD : EV_RUN_REV;
                    end
                end
            end
            CMD_TEST:
            begin
                if (tm != st.test_mode)
                begin
                    st_next.motion        = MOT_STOP;
                    st_next.target_active = 1'b0;
                    st_next.test_mode     = tm;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase

        // drive outputs from the updated state
        fw  = (st_next.motion == MOT_FWD);
        rv  = (st_next.motion == MOT_REV);
        br1 = fw || rv || (st_next.test_mode == TM_BR2);
        br2 = fw || rv || (st_next.test_mode == TM_BR1);

        st_next.last_br1 = br1;
        st_next.last_br2 = br2;

        res.accepted          = acc;
        res.motion_state      = st_next.motion;
        res.target_tracking   = st_next.target_active;
        res.test_mode_now     = st_next.test_mode;
        res.forward_contactor = fw;
        res.reverse_contactor = rv;
        res.brake_one_open    = br1;
        res.brake_two_open    = br2;
        res.brake_one_opened  = br1 && !st.last_br1;
        res.brake_two_opened  = br2 && !st.last_br2;
        res.event_code        = ev;
    end

endmodule

`default_nettype wire

### design/hoist_motion_interlock.sv
// Hoist motion interlock: an accepted command word is held in the input register, then goes
// through the step logic into the result register as its status word. Throughput is one word
// per cycle, set by the single pass through the step logic; a stalled output holds the
// input register, a word still enters behind a waiting result while that register is free.
// Reset clears motion, test mode, target, brake history and limits, and empties both stages.
`default_nettype none

`include "assert_macros.svh"

module hoist_motion_interlock
    import hmi_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0]      cfg_data,
    hmi_in_if.sink                          item,
    hmi_out_if.source                       result
);

    cfg_t    cfg_reg;
    item_t   in_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    advance;
    logic    take;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign take       = item.valid && item.ready;

    hmi_step u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .inp     (in_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UPPER_LIMIT: cfg_reg.upper_limit <= cfg_data[POS_WIDTH-1:0];
                REG_LOWER_LIMIT: cfg_reg.lower_limit <= cfg_data[POS_WIDTH-1:0];
                REG_DIRECT_MODE: cfg_reg.direct_mode <= cfg_data[0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take || advance)
        begin
            in_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.cmd               <= cmd_t'(item.cmd);
            in_reg.direction         <= item.direction;
            in_reg.target_position   <= item.target_position[POS_WIDTH-1:0];
            in_reg.test_mode_request <= item.test_mode_request;
            in_reg.position          <= item.position[POS_WIDTH-1:0];
            in_reg.supply_ok         <= item.supply_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.accepted          = res_reg.accepted;
    assign result.motion_state      = res_reg.motion_state;
    assign result.target_tracking   = res_reg.target_tracking;
    assign result.test_mode_now     = res_reg.test_mode_now;
    assign result.forward_contactor = res_reg.forward_contactor;
    assign result.reverse_contactor = res_reg.reverse_contactor;
    assign result.brake_one_open    = res_reg.brake_one_open;
    assign result.brake_two_open    = res_reg.brake_two_open;
    assign result.brake_one_opened  = res_reg.brake_one_opened;
    assign result.brake_two_opened  = res_reg.brake_two_opened;
    assign result.event_code        = res_reg.event_code;

    `ASSERT_ALWAYS(a_contactor_excl, !(out_valid_reg && res_reg.forward_contactor && res_reg.reverse_contactor), "both contactors closed")

    `ASSERT_IMPLIES(a_brakes_on_motion, out_valid_reg && (res_reg.motion_state != MOT_STOP), res_reg.brake_one_open && res_reg.brake_two_open, "motion with a brake applied")

    `ASSERT_NEXT(a_block_holds_motion, advance && !res_next.accepted, state_reg.motion == $past(state_reg.motion), "blocked command changed motion")

    `ASSERT_IMPLIES(a_ready_when_drained, !out_valid_reg, item.ready, "input stalled with empty output")

endmodule

`default_nettype wire
